FILE: rtl/core/jetp_pkg.sv
// Shared types, constants and fixed-point helpers for the Julia escape-time core.
// No dependencies; used by every module of the core.
`default_nettype none
package jetp_pkg;

    localparam int FRAC_BITS  = 28;
    localparam int MAX_DEGREE = 8;
    localparam int ZW         = 39;   // signed Q.28 value saturated to +-2^37
    localparam int WW         = 44;   // wide signed sum width before saturation
    localparam int QDEPTH     = 2;

    localparam logic signed [WW-1:0] SAT_POS = 44'sd137438953472;
    localparam logic signed [WW-1:0] SAT_NEG = -44'sd137438953472;
    localparam logic signed [WW-1:0] ESC_SQ  = 44'sd1073741824;

    // Register indexes of the configuration port
    localparam logic [2:0] REG_ORIGIN_RE = 3'd0;
    localparam logic [2:0] REG_ORIGIN_IM = 3'd1;
    localparam logic [2:0] REG_STEP_RE   = 3'd2;
    localparam logic [2:0] REG_STEP_IM   = 3'd3;
    localparam logic [2:0] REG_CONST_RE  = 3'd4;
    localparam logic [2:0] REG_CONST_IM  = 3'd5;
    localparam logic [2:0] REG_DEGREE    = 3'd6;
    localparam logic [2:0] REG_MAX_ITER  = 3'd7;

    typedef logic signed [ZW-1:0] t_zval;

    typedef struct packed {
        logic [10:0] col;
        logic [9:0]  row;
    } t_pixel_in;

    typedef struct packed {
        logic [10:0] out_col;
        logic [9:0]  out_row;
        logic        inside_res;
        logic [9:0]  escape_round;
    } t_pixel_out;

    typedef struct packed {
        logic [10:0] col;
        logic [9:0]  row;
        t_zval       zr;
        t_zval       zi;
    } t_job;

    typedef struct packed {
        logic signed [31:0] const_re;
        logic signed [31:0] const_im;
        logic [3:0]         degree;
        logic [9:0]         max_iter;
    } t_run_cfg;

    // Clamp a wide sum to +-2^37
    function automatic t_zval sat(input logic signed [WW-1:0] v);
        logic signed [WW-1:0] c;
        begin
            c = v;
            if (v > SAT_POS) c = SAT_POS;
            if (v < SAT_NEG) c = SAT_NEG;
            sat = c[ZW-1:0];
        end
    endfunction

    // Q.28 product on magnitudes, truncated toward zero, saturated
    function automatic t_zval qmul(input t_zval a, input t_zval b);
        logic        neg;
        logic [ZW-1:0] ua;
        logic [ZW-1:0] ub;
        logic [9:0]  ah;
        logic [9:0]  bh;
        logic [27:0] al;
        logic [27:0] bl;
        logic [55:0] ll;
        logic [49:0] m;
        logic [ZW-1:0] r;
        begin
            neg = a[ZW-1] ^ b[ZW-1];
            ua  = a[ZW-1] ? (~a + 1'b1) : a;
            ub  = b[ZW-1] ? (~b + 1'b1) : b;
            ah  = ua[37:28];
            al  = ua[27:0];
            bh  = ub[37:28];
            bl  = ub[27:0];
            ll  = 56'(al) * 56'(bl);
            m   = (50'(20'(ah) * 20'(bh)) << FRAC_BITS) + 50'(38'(ah) * 38'(bl))
                + 50'(38'(al) * 38'(bh)) + 50'(ll[55:28]);
            if (m > 50'd137438953472) m = 50'd137438953472;
            r   = m[ZW-1:0];
            qmul = neg ? t_zval'(~r + 1'b1) : t_zval'(r);
        end
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/jetp_front.sv
// Front end: maps an accepted pixel to its saturated start point.
// Depends on jetp_pkg.
`default_nettype none
module jetp_front (
    input  wire jetp_pkg::t_pixel_in i_pixel,
    input  wire logic signed [31:0]  i_origin_re,
    input  wire logic signed [31:0]  i_origin_im,
    input  wire logic [30:0]         i_step_re,
    input  wire logic [30:0]         i_step_im,
    output jetp_pkg::t_job           o_job
);
    logic [41:0] w_off_re;
    logic [40:0] w_off_im;
    logic signed [jetp_pkg::WW-1:0] w_sum_re;
    logic signed [jetp_pkg::WW-1:0] w_sum_im;

    // Scale the pixel position by the step sizes
    assign w_off_re = 42'(i_pixel.col) * 42'(i_step_re);
    assign w_off_im = 41'(i_pixel.row) * 41'(i_step_im);

    // Offset from the view corner and clamp
    assign w_sum_re = jetp_pkg::WW'(i_origin_re) + $signed({2'b00, w_off_re});
    assign w_sum_im = jetp_pkg::WW'(i_origin_im) + $signed({3'b000, w_off_im});

    assign o_job.col = i_pixel.col;
    assign o_job.row = i_pixel.row;
    assign o_job.zr  = jetp_pkg::sat(w_sum_re);
    assign o_job.zi  = jetp_pkg::sat(w_sum_im);
endmodule
`default_nettype wire

FILE: rtl/core/jetp_queue.sv
// Two-entry job queue between the front end and the iteration engine.
// Depends on jetp_pkg.
`default_nettype none
module jetp_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire jetp_pkg::t_job i_job,
    input  wire logic          i_pop,
    output jetp_pkg::t_job     o_job,
    output logic               o_valid,
    output logic               o_full
);
    jetp_pkg::t_job r_mem [jetp_pkg::QDEPTH];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;

    assign o_job   = r_mem[r_rd];
    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'(jetp_pkg::QDEPTH));

    // Store the pushed word
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wr <= ~r_wr;
            if (i_pop)  r_rd <= ~r_rd;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end
endmodule
`default_nettype wire

FILE: rtl/core/jetp_engine.sv
// Iteration engine: runs z = z^d + c with one shared Q.28 multiplier.
// Depends on jetp_pkg.
`default_nettype none
module jetp_engine (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire jetp_pkg::t_job     i_job,
    input  wire logic               i_job_valid,
    output logic                    o_pop,
    input  wire jetp_pkg::t_run_cfg i_cfg,
    output logic                    o_valid,
    output jetp_pkg::t_pixel_out    o_result
);
    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_ACC, S_ADDC, S_MAG, S_CHK
    } t_state;

    t_state r_state;
    logic [1:0] r_idx;
    logic [3:0] r_k;
    logic [9:0] r_i;
    logic [10:0] r_col;
    logic [9:0] r_row;
    jetp_pkg::t_zval r_zr, r_zi, r_pr, r_pi, r_p0, r_p1, r_p2, r_p3;
    logic r_valid;
    jetp_pkg::t_pixel_out r_res;

    logic [3:0] w_deg;
    logic [9:0] w_iters;
    jetp_pkg::t_zval w_a, w_b, w_prod;
    logic signed [jetp_pkg::WW-1:0] w_mag;

    // Clamp degree and round count
    always_comb begin
        w_deg = i_cfg.degree;
        if (i_cfg.degree < 4'd2) w_deg = 4'd2;
        if (i_cfg.degree > 4'(jetp_pkg::MAX_DEGREE)) w_deg = 4'(jetp_pkg::MAX_DEGREE);
        w_iters = (i_cfg.max_iter == 10'd0) ? 10'd1 : i_cfg.max_iter;
    end

    // Select multiplier operands
    always_comb begin
        w_a = r_zr;
        w_b = r_zr;
        if (r_state == S_MAG) begin
            w_a = r_idx[0] ? r_zi : r_zr;
            w_b = w_a;
        end else begin
            case (r_idx)
                2'd0: begin w_a = r_pr; w_b = r_zr; end
                2'd1: begin w_a = r_pi; w_b = r_zi; end
                2'd2: begin w_a = r_pr; w_b = r_zi; end
                default: begin w_a = r_pi; w_b = r_zr; end
            endcase
        end
    end

    assign w_prod = jetp_pkg::qmul(w_a, w_b);
    assign w_mag  = jetp_pkg::WW'(r_p0) + jetp_pkg::WW'(r_p1);
    assign o_pop  = (r_state == S_IDLE) && i_job_valid;
    assign o_valid  = r_valid;
    assign o_result = r_res;

    // Sequence the rounds
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_col   <= i_job.col;
                        r_row   <= i_job.row;
                        r_zr    <= i_job.zr;
                        r_zi    <= i_job.zi;
                        r_pr    <= i_job.zr;
                        r_pi    <= i_job.zi;
                        r_k     <= 4'd1;
                        r_i     <= 10'd0;
                        r_idx   <= 2'd0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    case (r_idx)
                        2'd0: r_p0 <= w_prod;
                        2'd1: r_p1 <= w_prod;
                        2'd2: r_p2 <= w_prod;
                        default: r_p3 <= w_prod;
                    endcase
                    r_idx <= r_idx + 2'd1;
                    if (r_idx == 2'd3) r_state <= S_ACC;
                end
                S_ACC: begin
                    r_pr <= jetp_pkg::sat(jetp_pkg::WW'(r_p0) - jetp_pkg::WW'(r_p1));
                    r_pi <= jetp_pkg::sat(jetp_pkg::WW'(r_p2) + jetp_pkg::WW'(r_p3));
                    if (r_k == w_deg - 4'd1) begin
                        r_state <= S_ADDC;
                    end else begin
                        r_k     <= r_k + 4'd1;
                        r_state <= S_MUL;
                    end
                end
                S_ADDC: begin
                    r_zr    <= jetp_pkg::sat(jetp_pkg::WW'(r_pr) + jetp_pkg::WW'(i_cfg.const_re));
                    r_zi    <= jetp_pkg::sat(jetp_pkg::WW'(r_pi) + jetp_pkg::WW'(i_cfg.const_im));
                    r_idx   <= 2'd0;
                    r_state <= S_MAG;
                end
                S_MAG: begin
                    if (r_idx[0]) begin
                        r_p1    <= w_prod;
                        r_state <= S_CHK;
                    end else begin
                        r_p0 <= w_prod;
                    end
                    r_idx <= r_idx + 2'd1;
                end
                S_CHK: begin
                    r_res.out_col <= r_col;
                    r_res.out_row <= r_row;
                    if (w_mag > jetp_pkg::ESC_SQ) begin
                        r_res.inside_res   <= 1'b0;
                        r_res.escape_round <= r_i;
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end else if (r_i == w_iters - 10'd1) begin
                        r_res.inside_res   <= 1'b1;
                        r_res.escape_round <= 10'd0;
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_i     <= r_i + 10'd1;
                        r_pr    <= r_zr;
                        r_pi    <= r_zi;
                        r_k     <= 4'd1;
                        r_idx   <= 2'd0;
                        r_state <= S_MUL;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: rtl/core/julia_escape_time_pixel_core.sv
// Top level of the Julia escape-time pixel core: APB register file and wiring.
// Depends on jetp_pkg, jetp_front, jetp_queue and jetp_engine.
//
//  channel  | handshake                     | payload
//  ---------+-------------------------------+---------------------
//  pixel in | start, busy (taken when !busy)| i_pixel (col, row)
//  result   | o_valid, one-cycle strobe     | o_result
//  config   | APB psel/penable/pwrite       | paddr, pwdata, prdata
//
// Each round (d = clamped degree) uses the single shared multiplier for four
// real products per complex multiply plus two for the magnitude.
// busy rises only when the two-entry job queue is full. Reset is
// synchronous; no clearing pass. The receiver cannot stall results.
`default_nettype none
module julia_escape_time_pixel_core (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire jetp_pkg::t_pixel_in  i_pixel,
    output logic                      o_valid,
    output jetp_pkg::t_pixel_out      o_result,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [4:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    logic signed [31:0] r_origin_re, r_origin_im, r_const_re, r_const_im;
    logic [30:0] r_step_re, r_step_im;
    logic [3:0]  r_degree;
    logic [9:0]  r_max_iter;

    logic w_wr, w_push, w_pop, w_qvalid, w_full;
    logic [2:0] w_idx;
    jetp_pkg::t_job w_job_in, w_job_out;
    jetp_pkg::t_run_cfg w_cfg;

    assign pready = 1'b1;
    assign w_idx  = paddr[4:2];
    assign w_wr   = psel && penable && pwrite;
    assign w_push = start && !busy;
    assign busy   = w_full;

    // Hold the configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_re <= -32'sd536870912;
            r_origin_im <= -32'sd268435456;
            r_step_re   <= 31'd629146;
            r_step_im   <= 31'd894785;
            r_const_re  <= 32'sd76504105;
            r_const_im  <= 32'sd2684355;
            r_degree    <= 4'd2;
            r_max_iter  <= 10'd200;
        end else if (w_wr) begin
            unique case (w_idx)
                jetp_pkg::REG_ORIGIN_RE: r_origin_re <= pwdata;
                jetp_pkg::REG_ORIGIN_IM: r_origin_im <= pwdata;
                jetp_pkg::REG_STEP_RE:   r_step_re   <= pwdata[30:0];
                jetp_pkg::REG_STEP_IM:   r_step_im   <= pwdata[30:0];
                jetp_pkg::REG_CONST_RE:  r_const_re  <= pwdata;
                jetp_pkg::REG_CONST_IM:  r_const_im  <= pwdata;
                jetp_pkg::REG_DEGREE:    r_degree    <= pwdata[3:0];
                jetp_pkg::REG_MAX_ITER:  r_max_iter  <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    // Decode register reads
    always_comb begin
        unique case (w_idx)
            jetp_pkg::REG_ORIGIN_RE: prdata = r_origin_re;
            jetp_pkg::REG_ORIGIN_IM: prdata = r_origin_im;
            jetp_pkg::REG_STEP_RE:   prdata = {1'b0, r_step_re};
            jetp_pkg::REG_STEP_IM:   prdata = {1'b0, r_step_im};
            jetp_pkg::REG_CONST_RE:  prdata = r_const_re;
            jetp_pkg::REG_CONST_IM:  prdata = r_const_im;
            jetp_pkg::REG_DEGREE:    prdata = {28'd0, r_degree};
            jetp_pkg::REG_MAX_ITER:  prdata = {22'd0, r_max_iter};
            default:                 prdata = 32'd0;
        endcase
    end

    assign w_cfg.const_re = r_const_re;
    assign w_cfg.const_im = r_const_im;
    assign w_cfg.degree   = r_degree;
    assign w_cfg.max_iter = r_max_iter;

    jetp_front u_front (
        .i_pixel     (i_pixel),
        .i_origin_re (r_origin_re),
        .i_origin_im (r_origin_im),
        .i_step_re   (r_step_re),
        .i_step_im   (r_step_im),
        .o_job       (w_job_in)
    );

    jetp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .i_pop   (w_pop),
        .o_job   (w_job_out),
        .o_valid (w_qvalid),
        .o_full  (w_full)
    );

    jetp_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (w_job_out),
        .i_job_valid (w_qvalid),
        .o_pop       (w_pop),
        .i_cfg       (w_cfg),
        .o_valid     (o_valid),
        .o_result    (o_result)
    );
endmodule
`default_nettype wire
